// ===== rtl/scu_pkg.sv =====
// shared types, constants and divisor tables for the sine / cosine taylor unit
// no dependencies; imported by every module of the unit
package scu_pkg;

  localparam int unsigned Frac     = 28;   // fraction bits of the series arithmetic
  localparam int unsigned AngW     = 32;   // input angle, Q8.24
  localparam int unsigned ValW     = 32;   // result, Q2.30
  localparam int unsigned MagW     = 30;   // reduced magnitude, Q.28, at most pi
  localparam int unsigned X2W      = 32;   // square of the magnitude, Q.28
  localparam int unsigned TermW    = 32;   // series term, unsigned Q.28
  localparam int unsigned ProdW    = 34;   // term * x2 >> 28, bounded below 2^34
  localparam int unsigned SumW     = 34;   // signed partial sum, Q.28
  localparam int unsigned DivW     = 7;    // per-term divisor
  localparam int unsigned RcpShift = 34;   // reciprocal scale for the term divisors
  localparam int unsigned NumTerms = 5;    // series terms after the leading 1.0

  // range reduction constants, Q.52
  localparam logic [55:0] TwoPiQ52 = 56'h64_87ED_5110_B461;
  localparam logic [55:0] PiQ52    = 56'h32_43F6_A888_5A31;

  // floor(2^68 / 2pi_q52): |angle| * QRcp >> 40 is the quotient or one below it
  localparam logic [127:0] QRcpFull = (128'd1 << 68) / {72'd0, TwoPiQ52};
  localparam logic [15:0]  QRcp     = QRcpFull[15:0];

  localparam logic [TermW-1:0] OneQ28 = 32'h1000_0000;

  typedef logic [DivW-1:0]     div_t;
  typedef logic [RcpShift-1:0] rcp_t;

  // word passed between the reduction, term and output sections
  typedef struct packed {
    logic                   cosine;
    logic                   neg;
    logic [MagW-1:0]        m;
    logic [X2W-1:0]         x2;
    logic [TermW-1:0]       term;
    logic signed [SumW-1:0] sum;
  } scu_item_t;

  // divisor of term k: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  function automatic div_t series_div(input logic [2:0] k, input logic cosine);
    div_t d;
    d = '0;
    unique case ({cosine, k})
      4'b0_001: d = 7'd6;
      4'b0_010: d = 7'd20;
      4'b0_011: d = 7'd42;
      4'b0_100: d = 7'd72;
      4'b0_101: d = 7'd110;
      4'b1_001: d = 7'd2;
      4'b1_010: d = 7'd12;
      4'b1_011: d = 7'd30;
      4'b1_100: d = 7'd56;
      4'b1_101: d = 7'd90;
      default:  d = 7'd1;
    endcase
    return d;
  endfunction

  // floor(2^34 / divisor), matching series_div
  function automatic rcp_t series_rcp(input logic [2:0] k, input logic cosine);
    rcp_t r;
    r = '0;
    unique case ({cosine, k})
      4'b0_001: r = rcp_t'((35'd1 << RcpShift) / 35'd6);
      4'b0_010: r = rcp_t'((35'd1 << RcpShift) / 35'd20);
      4'b0_011: r = rcp_t'((35'd1 << RcpShift) / 35'd42);
      4'b0_100: r = rcp_t'((35'd1 << RcpShift) / 35'd72);
      4'b0_101: r = rcp_t'((35'd1 << RcpShift) / 35'd110);
      4'b1_001: r = rcp_t'((35'd1 << RcpShift) / 35'd2);
      4'b1_010: r = rcp_t'((35'd1 << RcpShift) / 35'd12);
      4'b1_011: r = rcp_t'((35'd1 << RcpShift) / 35'd30);
      4'b1_100: r = rcp_t'((35'd1 << RcpShift) / 35'd56);
      4'b1_101: r = rcp_t'((35'd1 << RcpShift) / 35'd90);
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/scu_pipe_ctl.sv =====
// valid bits and per-stage load enables of a stallable register pipeline
// uses scu_pkg only for the common import convention
module scu_pipe_ctl
  import scu_pkg::*;
#(
  parameter int unsigned Stages = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [Stages-1:0] load_o
);

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] vld_in;
  logic [Stages:0]   load;

  // a stage loads when it is empty or its word moves on
  assign load[Stages] = out_ready_i;
  for (genvar i = 0; i < Stages; i++) begin : g_load
    assign load[i] = ~vld_q[i] | load[i+1];
  end

  assign vld_in = {vld_q[Stages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < Stages; i++) begin
        if (load[i]) begin
          vld_q[i] <= vld_in[i];
        end
      end
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = vld_q[Stages-1];
  assign load_o      = load[Stages-1:0];

endmodule

// ===== rtl/scu_reduce.sv =====
// range reduction by 2pi, fold into [-pi, pi] and squaring, seven stages
// depends on scu_pkg and scu_pipe_ctl
module scu_reduce
  import scu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  input  logic signed [AngW-1:0] angle_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output scu_item_t              out_item_o
);

  localparam int unsigned Stages = 7;

  logic [Stages-1:0] ld;

  scu_pipe_ctl #(.Stages(Stages)) u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .load_o     (ld)
  );

  logic [Stages-1:0] cos_q;
  logic [Stages-3:0] sgn_q;
  logic [AngW-1:0]   abs0_q, abs1_q, abs2_q;
  logic [4:0]        qe1_q;
  logic [59:0]       qt2_q;
  logic [55:0]       r3_q, rm4_q;
  logic [MagW-1:0]   m5_q, m6_q;
  logic              neg5_q, neg6_q;
  logic [X2W-1:0]    x26_q;

  logic [AngW-1:0] ang_u, abs_d;
  logic [47:0]     qprod;
  logic [60:0]     qt_full;
  logic [59:0]     a_q52;
  logic [59:0]     r_full;
  logic [55:0]     rm_d, diff, mag;
  logic            over, neg_d;
  logic [59:0]     sq;

  assign ang_u = angle_i;
  assign abs_d = ang_u[AngW-1] ? (~ang_u + 1'b1) : ang_u;

  // quotient estimate, at most one below the true quotient
  assign qprod   = abs0_q * QRcp;
  assign qt_full = qe1_q * TwoPiQ52;
  assign a_q52   = {abs2_q, 28'd0};
  assign r_full  = a_q52 - qt2_q;

  // one correction step
  assign rm_d = (r3_q >= TwoPiQ52) ? (r3_q - TwoPiQ52) : r3_q;

  // fold past pi back by one period, sign follows
  assign over  = rm4_q > PiQ52;
  assign diff  = TwoPiQ52 - rm4_q;
  assign mag   = over ? diff : rm4_q;
  assign neg_d = over ? ~sgn_q[4] : (sgn_q[4] & (rm4_q != '0));

  assign sq = m5_q * m5_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      cos_q[0] <= mode_i;
      sgn_q[0] <= ang_u[AngW-1];
      abs0_q   <= abs_d;
    end
    for (int i = 1; i < Stages; i++) begin
      if (ld[i]) begin
        cos_q[i] <= cos_q[i-1];
      end
    end
    for (int i = 1; i < Stages - 2; i++) begin
      if (ld[i]) begin
        sgn_q[i] <= sgn_q[i-1];
      end
    end
    if (ld[1]) begin
      qe1_q  <= qprod[44:40];
      abs1_q <= abs0_q;
    end
    if (ld[2]) begin
      qt2_q  <= qt_full[59:0];
      abs2_q <= abs1_q;
    end
    if (ld[3]) begin
      r3_q <= r_full[55:0];
    end
    if (ld[4]) begin
      rm4_q <= rm_d;
    end
    if (ld[5]) begin
      m5_q   <= mag[53:24];
      neg5_q <= neg_d;
    end
    if (ld[6]) begin
      m6_q   <= m5_q;
      neg6_q <= neg5_q;
      x26_q  <= sq[59:28];
    end
  end

  always_comb begin
    out_item_o        = '0;
    out_item_o.cosine = cos_q[Stages-1];
    out_item_o.neg    = neg6_q;
    out_item_o.m      = m6_q;
    out_item_o.x2     = x26_q;
    out_item_o.term   = OneQ28;
    out_item_o.sum    = '0;
  end

endmodule

// ===== rtl/scu_term.sv =====
// one series step: adds the previous term to the sum and forms the next term
// depends on scu_pkg and scu_pipe_ctl
module scu_term
  import scu_pkg::*;
#(
  parameter int unsigned K = 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  scu_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output scu_item_t out_item_o
);

  localparam int unsigned Stages   = 3;
  localparam logic [2:0]  KIdx     = 3'(K);
  // the incoming term has index K-1; odd indexes are subtracted
  localparam bit          Subtract = ((K - 1) % 2) == 1;

  logic [Stages-1:0] ld;

  scu_pipe_ctl #(.Stages(Stages)) u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .load_o     (ld)
  );

  scu_item_t          it0_q, it1_q, it2_q;
  scu_item_t          it0_d, it2_d;
  logic [ProdW-1:0]   p0_q, p1_q;
  logic [RcpShift:0]  qe1_q;

  logic [63:0]            prod;
  logic signed [SumW-1:0] term_s;
  logic [67:0]            est;
  logic [39:0]            qd;
  logic [ProdW-1:0]       rem;
  logic [RcpShift:0]      qfix;
  div_t                   div;

  assign prod   = in_item_i.term * in_item_i.x2;
  assign term_s = $signed({2'b00, in_item_i.term});

  always_comb begin
    it0_d     = in_item_i;
    it0_d.sum = Subtract ? (in_item_i.sum - term_s) : (in_item_i.sum + term_s);
  end

  // reciprocal estimate, then one compare fixes the truncated quotient
  assign est  = p0_q * series_rcp(KIdx, it0_q.cosine);
  assign div  = series_div(KIdx, it1_q.cosine);
  assign qd   = qe1_q * div;
  assign rem  = p1_q - qd[ProdW-1:0];
  assign qfix = (rem >= {{(ProdW-DivW){1'b0}}, div}) ? (qe1_q + 1'b1) : qe1_q;

  always_comb begin
    it2_d      = it1_q;
    it2_d.term = qfix[TermW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      it0_q <= it0_d;
      p0_q  <= prod[Frac+ProdW-1:Frac];
    end
    if (ld[1]) begin
      it1_q <= it0_q;
      p1_q  <= p0_q;
      qe1_q <= {1'b0, est[67:RcpShift]};
    end
    if (ld[2]) begin
      it2_q <= it2_d;
    end
  end

  assign out_item_o = it2_q;

endmodule

// ===== rtl/scu_final.sv =====
// last term, sign and scaling of the result into Q2.30, four stages
// depends on scu_pkg and scu_pipe_ctl
module scu_final
  import scu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  scu_item_t              in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [ValW-1:0] value_o
);

  localparam int unsigned Stages  = 4;
  localparam bit          LastSub = (NumTerms % 2) == 1;

  logic [Stages-1:0] ld;

  scu_pipe_ctl #(.Stages(Stages)) u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .load_o     (ld)
  );

  logic signed [SumW-1:0] sum0_q;
  logic                   cos0_q, cos1_q, neg0_q;
  logic [MagW-1:0]        m0_q, m1_q;
  logic [SumW-1:0]        abs1_q;
  logic [ValW-1:0]        cv1_q;
  logic                   flip1_q, flip2_q;
  logic [ValW-1:0]        mag2_q, val3_q;

  logic signed [SumW-1:0] term_s, sum_d;
  logic [SumW-1:0]        sum_u, abs_d;
  logic [63:0]            sprod;
  logic [ValW-1:0]        mag_d;

  assign term_s = $signed({2'b00, in_item_i.term});
  assign sum_d  = LastSub ? (in_item_i.sum - term_s) : (in_item_i.sum + term_s);

  assign sum_u = sum0_q;
  assign abs_d = sum_u[SumW-1] ? (~sum_u + 1'b1) : sum_u;

  // sine: m * |sum| >> 26; cosine: sum * 4
  assign sprod = m1_q * abs1_q;
  assign mag_d = cos1_q ? cv1_q : sprod[57:26];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      sum0_q <= sum_d;
      cos0_q <= in_item_i.cosine;
      neg0_q <= in_item_i.neg;
      m0_q   <= in_item_i.m;
    end
    if (ld[1]) begin
      abs1_q  <= abs_d;
      cos1_q  <= cos0_q;
      m1_q    <= m0_q;
      cv1_q   <= {sum_u[ValW-3:0], 2'b00};
      flip1_q <= ~cos0_q & (neg0_q ^ sum_u[SumW-1]);
    end
    if (ld[2]) begin
      mag2_q  <= mag_d;
      flip2_q <= flip1_q;
    end
    if (ld[3]) begin
      val3_q <= flip2_q ? (~mag2_q + 1'b1) : mag2_q;
    end
  end

  assign value_o = $signed(val3_q);

endmodule

// ===== rtl/sine_cosine_taylor_unit.sv =====
// top level of the sine / cosine taylor unit: reduction, five series steps, output
// depends on scu_pkg, scu_pipe_ctl, scu_reduce, scu_term and scu_final
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_ready_o   mode_i (1), angle_i (32, Q8.24)
//   out      source     out_valid_o / out_ready_i value_o (32, Q2.30)
//
// one word per cycle sustained while out_ready_i is high; from input to output every word passes
// 7 stages of range reduction, 3 stages for each of the five series terms
// (product, reciprocal multiply, quotient fix) and 4 output stages
// reset clears only the valid bits; the data registers are not reset
// each stage loads when empty or when its word moves on, so a stalled output
// holds its word while the pipeline behind it keeps filling its bubbles
module sine_cosine_taylor_unit
  import scu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  input  logic signed [AngW-1:0] angle_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [ValW-1:0] value_o
);

  // chain between the sections: index 0 leaves the reduction,
  // index NumTerms enters the output section
  logic [NumTerms:0] chain_vld;
  logic [NumTerms:0] chain_rdy;
  scu_item_t         chain_item [NumTerms+1];

  // angle mod 2pi, fold, |x| and x^2
  scu_reduce u_reduce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .angle_i    (angle_i),
    .out_valid_o(chain_vld[0]),
    .out_ready_i(chain_rdy[0]),
    .out_item_o (chain_item[0])
  );

  // series steps, term k = term k-1 * x2 / divisor, sum kept one term behind
  for (genvar k = 0; k < NumTerms; k++) begin : g_term
    scu_term #(.K(k + 1)) u_term (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (chain_vld[k]),
      .in_ready_o (chain_rdy[k]),
      .in_item_i  (chain_item[k]),
      .out_valid_o(chain_vld[k+1]),
      .out_ready_i(chain_rdy[k+1]),
      .out_item_o (chain_item[k+1])
    );
  end

  // last term, sign handling and output register
  scu_final u_final (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (chain_vld[NumTerms]),
    .in_ready_o (chain_rdy[NumTerms]),
    .in_item_i  (chain_item[NumTerms]),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o)
  );

`ifndef ASSERT_OFF
  // input can only be held off by a full pipeline behind a stalled output word
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked output word");

  // reduced angle lies in [-pi, pi], so the series stays close to unit magnitude
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((value_o <= 32'sh4080_0000) && (value_o >= -32'sh4080_0000)))
    else $error("result magnitude out of range");
`endif

endmodule
